// ===== hdl/tbfh_pkg.sv =====
// ============================================================================
// Tiled bubble field height: shared package
// Types, codes and constants used by the sequencer, the score pipeline and
// the tile damping unit.
// ============================================================================
`default_nettype none

package tbfh_pkg;

    // Function codes carried by an input word.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Tile offset codes along one axis.
    localparam logic [1:0] TILE_NEG = 2'd0;
    localparam logic [1:0] TILE_MID = 2'd1;
    localparam logic [1:0] TILE_POS = 2'd2;

    // One tile width in Q0.16, as an offset and as a weight.
    localparam logic signed [17:0] OFF_NEG = -18'sd65536;
    localparam logic signed [17:0] OFF_MID = 18'sd0;
    localparam logic signed [17:0] OFF_POS = 18'sd65536;
    localparam logic [16:0]        ONE_Q16 = 17'd65536;

    // Largest Q0.16 output value.
    localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;

    // Depth of the score pipeline from table data to score.
    localparam int EVAL_STAGES = 9;

    // Width of the bubble count register.
    localparam int COUNT_W = 6;

    // One bubble record as held in the table.
    typedef struct packed {
        logic [23:0]        inv_scale;
        logic [15:0]        inv_squish;
        logic [15:0]        squish;
        logic signed [15:0] sin_angle;
        logic signed [15:0] cos_angle;
        logic [15:0]        center_v;
        logic [15:0]        center_h;
    } bubble_rec_t;

    localparam int REC_W = $bits(bubble_rec_t);

    // Tag that travels with one bubble and tile evaluation.
    typedef struct packed {
        logic       first;
        logic       last;
        logic [1:0] tile_h;
        logic [1:0] tile_v;
    } eval_tag_t;

    // Score pipeline output toward the damping unit.
    typedef struct packed {
        logic       valid;
        eval_tag_t  tag;
        logic [16:0] score;
    } eval_out_t;

    // Damping unit status toward the sequencer.
    typedef struct packed {
        logic        done;
        logic [16:0] best;
    } damp_stat_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/tbfh_ram.sv =====
// ============================================================================
// Tiled bubble field height: generic RAM
// Single write port, single read port with registered read data.
// ============================================================================
`default_nettype none

module tbfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                                      aclk,
    input  wire                                      wr_en,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire [WIDTH-1:0]                          wr_data,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/tbfh_eval.sv =====
// ============================================================================
// Tiled bubble field height: bubble score pipeline
// Takes one bubble record and tile offset per cycle and returns its
// registered score in Q0.16 (0 to 1.0).
// ============================================================================
`default_nettype none

module tbfh_eval (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       in_valid,
    input  tbfh_pkg::eval_tag_t       in_tag,
    input  tbfh_pkg::bubble_rec_t     in_rec,
    input  wire [15:0]                pixel_h,
    input  wire [15:0]                pixel_v,
    output tbfh_pkg::eval_out_t       eval_out
);

    localparam int NSTG = tbfh_pkg::EVAL_STAGES;

    logic [NSTG-1:0]     vld_reg;
    tbfh_pkg::eval_tag_t tag_reg [NSTG];

    // Stage 1: offsets from the bubble centre.
    logic signed [17:0] x1_reg, y1_reg, x1_next, y1_next;
    logic signed [17:0] off_h, off_v;
    logic signed [15:0] c1_reg, s1_reg;
    logic [15:0]        sq1_reg, isq1_reg;
    logic [23:0]        isc1_reg;
    // Stage 2: rotation products.
    logic signed [33:0] xc2_reg, ys2_reg, xs2_reg, yc2_reg;
    logic [15:0]        sq2_reg, isq2_reg;
    logic [23:0]        isc2_reg;
    // Stage 3: rotated coordinates.
    logic signed [34:0] dt3, du3;
    logic signed [19:0] t3_reg, u3_reg;
    logic [15:0]        sq3_reg, isq3_reg;
    logic [23:0]        isc3_reg;
    // Stage 4: squished coordinates.
    logic signed [36:0] ph4, pv4;
    logic signed [22:0] hs4_reg, vs4_reg;
    logic [23:0]        isc4_reg;
    // Stage 5: squares.
    logic signed [45:0] hh5, vv5;
    logic [42:0]        hh5_reg, vv5_reg;
    logic [23:0]        isc5_reg;
    // Stage 6: distance squared.
    logic [43:0]        d2_6_reg;
    logic [23:0]        isc6_reg;
    // Stage 7: partial products of the scale term.
    logic [43:0]        pph7_reg, ppl7_reg;
    logic               big7_reg, nz7_reg;
    // Stage 8: full scale term, reduced to an overflow flag and low bits.
    logic [64:0]        sum8;
    logic               over8_reg;
    logic [39:0]        low8_reg;
    // Stage 9: score.
    logic [40:0]        diff9;
    logic [16:0]        score9_reg;

    // Tile offsets for the current tag.
    always_comb begin
        unique case (in_tag.tile_h)
            tbfh_pkg::TILE_NEG: off_h = tbfh_pkg::OFF_NEG;
            tbfh_pkg::TILE_POS: off_h = tbfh_pkg::OFF_POS;
            default:            off_h = tbfh_pkg::OFF_MID;
        endcase
        unique case (in_tag.tile_v)
            tbfh_pkg::TILE_NEG: off_v = tbfh_pkg::OFF_NEG;
            tbfh_pkg::TILE_POS: off_v = tbfh_pkg::OFF_POS;
            default:            off_v = tbfh_pkg::OFF_MID;
        endcase
        x1_next = $signed({2'b00, pixel_h}) - $signed({2'b00, in_rec.center_h}) + off_h;
        y1_next = $signed({2'b00, pixel_v}) - $signed({2'b00, in_rec.center_v}) + off_v;
    end

    // Arithmetic between the pipeline registers.
    always_comb begin
        dt3   = $signed({xc2_reg[33], xc2_reg}) - $signed({ys2_reg[33], ys2_reg});
        du3   = $signed({xs2_reg[33], xs2_reg}) + $signed({yc2_reg[33], yc2_reg});
        ph4   = t3_reg * $signed({1'b0, sq3_reg});
        pv4   = u3_reg * $signed({1'b0, isq3_reg});
        hh5   = hs4_reg * hs4_reg;
        vv5   = vs4_reg * vs4_reg;
        sum8  = {1'b0, pph7_reg, 20'b0} + {21'b0, ppl7_reg};
        diff9 = {1'b1, 40'b0} - {1'b0, low8_reg};
    end

    // Valid bits and tags move down the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
        tag_reg[0] <= in_tag;
        for (int i = 1; i < NSTG; i++) begin
            tag_reg[i] <= tag_reg[i-1];
        end
    end

    // Payload registers; floor division by powers of two keeps the upper bits.
    always_ff @(posedge aclk) begin
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        c1_reg   <= in_rec.cos_angle;
        s1_reg   <= in_rec.sin_angle;
        sq1_reg  <= in_rec.squish;
        isq1_reg <= in_rec.inv_squish;
        isc1_reg <= in_rec.inv_scale;

        xc2_reg  <= x1_reg * c1_reg;
        ys2_reg  <= y1_reg * s1_reg;
        xs2_reg  <= x1_reg * s1_reg;
        yc2_reg  <= y1_reg * c1_reg;
        sq2_reg  <= sq1_reg;
        isq2_reg <= isq1_reg;
        isc2_reg <= isc1_reg;

        t3_reg   <= dt3[34:15];
        u3_reg   <= du3[34:15];
        sq3_reg  <= sq2_reg;
        isq3_reg <= isq2_reg;
        isc3_reg <= isc2_reg;

        hs4_reg  <= ph4[35:13];
        vs4_reg  <= pv4[35:13];
        isc4_reg <= isc3_reg;

        hh5_reg  <= hh5[42:0];
        vv5_reg  <= vv5[42:0];
        isc5_reg <= isc4_reg;

        d2_6_reg <= {1'b0, hh5_reg} + {1'b0, vv5_reg};
        isc6_reg <= isc5_reg;

        pph7_reg <= d2_6_reg[39:20] * isc6_reg;
        ppl7_reg <= d2_6_reg[19:0] * isc6_reg;
        big7_reg <= |d2_6_reg[43:40];
        nz7_reg  <= |isc6_reg;

        over8_reg <= (big7_reg & nz7_reg) | (|sum8[64:40]);
        low8_reg  <= sum8[39:0];

        score9_reg <= over8_reg ? 17'd0 : diff9[40:24];
    end

    assign eval_out.valid = vld_reg[NSTG-1];
    assign eval_out.tag   = tag_reg[NSTG-1];
    assign eval_out.score = score9_reg;

endmodule

`default_nettype wire

// ===== hdl/tbfh_damp.sv =====
// ============================================================================
// Tiled bubble field height: tile maximum and edge damping
// Keeps the best score of the current tile, weights each finished tile by
// its edge weights and keeps the best damped value of the query.
// ============================================================================
`default_nettype none

module tbfh_damp (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    start,
    input  tbfh_pkg::eval_out_t    eval_in,
    input  wire [15:0]             pixel_h,
    input  wire [15:0]             pixel_v,
    output tbfh_pkg::damp_stat_t   status
);

    logic [16:0] tile_max_reg, tile_cur;
    logic        a_valid_reg;
    logic [16:0] a_val_reg;
    logic [1:0]  a_th_reg, a_tv_reg;
    logic        d1_valid_reg, d1_final_reg;
    logic [32:0] m1_reg;
    logic [16:0] wv1_reg;
    logic [33:0] prod1;
    logic [16:0] wh_a, wv_a;
    logic        d2_valid_reg, d2_final_reg;
    logic [49:0] prod2;
    logic [16:0] damped_reg;
    logic [16:0] best_reg;
    logic        done_reg;

    // Edge weight of a tile along one axis.
    function automatic logic [16:0] edge_weight(input logic [1:0] idx, input logic [15:0] pix);
        logic [16:0] w;
        unique case (idx)
            tbfh_pkg::TILE_NEG: w = {1'b0, pix};
            tbfh_pkg::TILE_POS: w = tbfh_pkg::ONE_Q16 - {1'b0, pix};
            default:            w = tbfh_pkg::ONE_Q16;
        endcase
        return w;
    endfunction

    // Running maximum within a tile and weight products.
    always_comb begin
        if (eval_in.tag.first || (eval_in.score > tile_max_reg)) begin
            tile_cur = eval_in.score;
        end else begin
            tile_cur = tile_max_reg;
        end
        wh_a  = edge_weight(a_th_reg, pixel_h);
        wv_a  = edge_weight(a_tv_reg, pixel_v);
        prod1 = a_val_reg * wh_a;
        prod2 = m1_reg * wv1_reg;
    end

    // Control bits of the damping stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            a_valid_reg  <= eval_in.valid & eval_in.tag.last;
            d1_valid_reg <= a_valid_reg;
            d2_valid_reg <= d1_valid_reg;
            done_reg     <= d2_valid_reg & d2_final_reg;
        end
    end

    // Payload of the damping stages; corner tiles take both weights.
    always_ff @(posedge aclk) begin
        if (eval_in.valid) begin
            tile_max_reg <= tile_cur;
        end
        a_val_reg    <= tile_cur;
        a_th_reg     <= eval_in.tag.tile_h;
        a_tv_reg     <= eval_in.tag.tile_v;

        m1_reg       <= prod1[32:0];
        wv1_reg      <= wv_a;
        d1_final_reg <= (a_th_reg == tbfh_pkg::TILE_POS) && (a_tv_reg == tbfh_pkg::TILE_POS);

        damped_reg   <= prod2[48:32];
        d2_final_reg <= d1_final_reg;

        if (start) begin
            best_reg <= '0;
        end else if (d2_valid_reg && (damped_reg > best_reg)) begin
            best_reg <= damped_reg;
        end
    end

    assign status.done = done_reg;
    assign status.best = best_reg;

endmodule

`default_nettype wire

// ===== hdl/tiled_bubble_field_height_core.sv =====
// A load word gives no result. A query scans N = min(bubble_count,
// MAX_BUBBLE_SLOTS) bubbles in each of the nine tiles, and returns zero
// height when N is zero. The block takes no new word until the result is
// delivered. The single score pipeline takes one bubble and tile pair per
// cycle for all nine tiles.
// Reset: synchronous, active low; clears sequencer and count, not the table.
// ============================================================================
// Tiled bubble field height: top level
// Sequencer, bubble table, score pipeline and tile damping for the bubble
// texture height query.
// ============================================================================
`default_nettype none

module tiled_bubble_field_height_core #(
    parameter int MAX_BUBBLE_SLOTS = 32
) (
    input  wire                aclk,
    input  wire                aresetn,
    // Configuration port.
    input  wire                cfg_wr_en,
    input  wire [5:0]          cfg_wr_data,
    // Input channel.
    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_func,
    input  wire [4:0]          s_bubble_index,
    input  wire [15:0]         s_center_h,
    input  wire [15:0]         s_center_v,
    input  wire signed [15:0]  s_cos_angle,
    input  wire signed [15:0]  s_sin_angle,
    input  wire [15:0]         s_squish,
    input  wire [15:0]         s_inv_squish,
    input  wire [23:0]         s_inv_scale,
    input  wire [15:0]         s_pixel_h,
    input  wire [15:0]         s_pixel_v,
    // Result channel.
    output logic               m_valid,
    input  wire                m_ready,
    output logic [15:0]        m_height
);

    localparam int AW = (MAX_BUBBLE_SLOTS > 1) ? $clog2(MAX_BUBBLE_SLOTS) : 1;
    localparam int CW = $clog2(MAX_BUBBLE_SLOTS + 1);

    tbfh_pkg::state_t state_reg, state_next;

    logic [tbfh_pkg::COUNT_W-1:0] bubble_count_reg;
    logic [CW-1:0]  n_reg, n_next, n_eff;
    logic [CW-1:0]  bub_reg, bub_next;
    logic [1:0]     th_reg, th_next, tv_reg, tv_next;
    logic [15:0]    pixel_h_reg, pixel_h_next, pixel_v_reg, pixel_v_next;
    logic [15:0]    height_reg, height_next;
    logic           rd_valid_reg;
    tbfh_pkg::eval_tag_t rd_tag_reg, issue_tag;
    logic           issue;
    logic           damp_start;
    logic           ram_we;
    logic           slot_ok;
    logic           bub_last;

    tbfh_pkg::bubble_rec_t wr_rec, rd_rec;
    logic [tbfh_pkg::REC_W-1:0] rd_data;
    tbfh_pkg::eval_out_t  eval_out;
    tbfh_pkg::damp_stat_t damp_stat;

    // Bubble count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bubble_count_reg <= '0;
        end else if (cfg_wr_en) begin
            bubble_count_reg <= cfg_wr_data;
        end
    end

    // Effective bubble count and table write decode.
    always_comb begin
        if (32'(bubble_count_reg) > 32'(MAX_BUBBLE_SLOTS)) begin
            n_eff = CW'(MAX_BUBBLE_SLOTS);
        end else begin
            n_eff = CW'(bubble_count_reg);
        end
        slot_ok = 32'(s_bubble_index) < 32'(MAX_BUBBLE_SLOTS);
        wr_rec.inv_scale  = s_inv_scale;
        wr_rec.inv_squish = s_inv_squish;
        wr_rec.squish     = s_squish;
        wr_rec.sin_angle  = s_sin_angle;
        wr_rec.cos_angle  = s_cos_angle;
        wr_rec.center_v   = s_center_v;
        wr_rec.center_h   = s_center_h;
        bub_last = (bub_reg == (n_reg - CW'(1)));
    end

    // Sequencer: next state, counters and handshake outputs.
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        bub_next     = bub_reg;
        th_next      = th_reg;
        tv_next      = tv_reg;
        pixel_h_next = pixel_h_reg;
        pixel_v_next = pixel_v_reg;
        height_next  = height_reg;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        ram_we       = 1'b0;
        issue        = 1'b0;
        damp_start   = 1'b0;
        issue_tag.first  = (bub_reg == '0);
        issue_tag.last   = bub_last;
        issue_tag.tile_h = th_reg;
        issue_tag.tile_v = tv_reg;

        unique case (state_reg)
            tbfh_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == tbfh_pkg::FUNC_LOAD) begin
                        ram_we = slot_ok;
                    end else begin
                        pixel_h_next = s_pixel_h;
                        pixel_v_next = s_pixel_v;
                        n_next       = n_eff;
                        bub_next     = '0;
                        th_next      = tbfh_pkg::TILE_NEG;
                        tv_next      = tbfh_pkg::TILE_NEG;
                        damp_start   = 1'b1;
                        if (n_eff == '0) begin
                            height_next = '0;
                            state_next  = tbfh_pkg::ST_RESP;
                        end else begin
                            state_next  = tbfh_pkg::ST_RUN;
                        end
                    end
                end
            end
            tbfh_pkg::ST_RUN: begin
                issue = 1'b1;
                if (bub_last) begin
                    bub_next = '0;
                    if (th_reg == tbfh_pkg::TILE_POS) begin
                        th_next = tbfh_pkg::TILE_NEG;
                        if (tv_reg == tbfh_pkg::TILE_POS) begin
                            state_next = tbfh_pkg::ST_DRAIN;
                        end else begin
                            tv_next = tv_reg + 2'd1;
                        end
                    end else begin
                        th_next = th_reg + 2'd1;
                    end
                end else begin
                    bub_next = bub_reg + CW'(1);
                end
            end
            tbfh_pkg::ST_DRAIN: begin
                if (damp_stat.done) begin
                    height_next = damp_stat.best[16] ? tbfh_pkg::HEIGHT_MAX
                                                     : damp_stat.best[15:0];
                    state_next  = tbfh_pkg::ST_RESP;
                end
            end
            tbfh_pkg::ST_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = tbfh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tbfh_pkg::ST_IDLE;
            end
        endcase
    end

    // State register and control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tbfh_pkg::ST_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
        end
    end

    // Query payload and counters.
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        bub_reg     <= bub_next;
        th_reg      <= th_next;
        tv_reg      <= tv_next;
        pixel_h_reg <= pixel_h_next;
        pixel_v_reg <= pixel_v_next;
        height_reg  <= height_next;
        rd_tag_reg  <= issue_tag;
    end

    // Bubble table.
    tbfh_ram #(
        .WIDTH (tbfh_pkg::REC_W),
        .DEPTH (MAX_BUBBLE_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(s_bubble_index)),
        .wr_data (wr_rec),
        .rd_addr (bub_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_rec = rd_data;

    // Score pipeline.
    tbfh_eval u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_valid_reg),
        .in_tag   (rd_tag_reg),
        .in_rec   (rd_rec),
        .pixel_h  (pixel_h_reg),
        .pixel_v  (pixel_v_reg),
        .eval_out (eval_out)
    );

    // Tile maximum and damping.
    tbfh_damp u_damp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (damp_start),
        .eval_in (eval_out),
        .pixel_h (pixel_h_reg),
        .pixel_v (pixel_v_reg),
        .status  (damp_stat)
    );

    assign m_height = height_reg;

endmodule

`default_nettype wire

// ===== hdl/tbfh_checker.sv =====
// ============================================================================
// Tiled bubble field height: port checker
// Watches the handshake ports of the top level and checks the order of
// words and results over time.
// ============================================================================
`default_nettype none

module tbfh_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        s_func,
    input wire        m_valid,
    input wire        m_ready,
    input wire [15:0] m_height
);

    // A stalled result holds its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_height)))
        else $error("result changed while stalled");

    // The block never takes a word while a result waits.
    a_busy_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while result pending");

    // A load word never produces a result.
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == tbfh_pkg::FUNC_LOAD)) |=> (s_ready && !m_valid))
        else $error("load word produced a result");

    // A query word makes the block busy.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == tbfh_pkg::FUNC_QUERY)) |=> !s_ready)
        else $error("block stayed ready after a query");

    // A delivered result frees the block.
    a_result_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (s_ready && !m_valid))
        else $error("block not ready after result delivery");

endmodule

bind tiled_bubble_field_height_core tbfh_checker u_tbfh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_func   (s_func),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_height (m_height)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ============================================================================
// Tiled bubble field height: testbench
// Loads bubble records, programs the bubble count and queries pixel heights.
// Every query's height is predicted from a local copy of the bubble table
// and compared with the word that the block returns. Directed records cover
// field extremes, saturation at one and oversized score terms. Random phases
// then vary the count, idling and back-pressure.
// ============================================================================
`default_nettype none

module tb;

    localparam int SLOTS = 32;
    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 6;
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int LOAD_SETTLE = 8;
    localparam int END_WAIT = 9 * SLOTS + 100;
    localparam int REPORT_MAX = 10;
    localparam int SEND_IDLE_PCT = 56;
    localparam int RECV_STALL_PCT = 56;
    localparam int BOTH_IDLE_PCT = 15;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int PHASE_WORDS = 55;
    localparam longint unsigned SCORE_ONE = 64'd1 << 40;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One input word as the sender sees it.
    typedef struct {
        logic                  func;
        logic [4:0]            slot;
        tbfh_pkg::bubble_rec_t rec;
        logic [15:0]           pixel_h;
        logic [15:0]           pixel_v;
    } field_word_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [5:0]         cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_func = 1'b0;
    logic [4:0]         s_bubble_index = '0;
    logic [15:0]        s_center_h = '0;
    logic [15:0]        s_center_v = '0;
    logic signed [15:0] s_cos_angle = '0;
    logic signed [15:0] s_sin_angle = '0;
    logic [15:0]        s_squish = '0;
    logic [15:0]        s_inv_squish = '0;
    logic [23:0]        s_inv_scale = '0;
    logic [15:0]        s_pixel_h = '0;
    logic [15:0]        s_pixel_v = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_height;

    // Local copy of the block's state and the expected heights in flight.
    tbfh_pkg::bubble_rec_t bubble_table [SLOTS];
    logic [5:0]  scan_count = '0;
    logic [15:0] expected_heights [$];
    logic [15:0] height_due;

    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off_left = 0;
    int     failure_count = 0;
    longint cycle_count = 0;

    tiled_bubble_field_height_core #(
        .MAX_BUBBLE_SLOTS(SLOTS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_bubble_index (s_bubble_index),
        .s_center_h     (s_center_h),
        .s_center_v     (s_center_v),
        .s_cos_angle    (s_cos_angle),
        .s_sin_angle    (s_sin_angle),
        .s_squish       (s_squish),
        .s_inv_squish   (s_inv_squish),
        .s_inv_scale    (s_inv_scale),
        .s_pixel_h      (s_pixel_h),
        .s_pixel_v      (s_pixel_v),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_height       (m_height)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Cycle counter and watchdog.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Height prediction
    // ------------------------------------------------------------------------

    // Score of one bubble at offset (x, y) from its centre, Q0.16 up to 1.0.
    function automatic logic [16:0] bubble_score(input longint x, input longint y,
                                                 input tbfh_pkg::bubble_rec_t r);
        longint c, s, t, u, hs, vs;
        longint unsigned d2, isc, p;
        c = $signed(r.cos_angle);
        s = $signed(r.sin_angle);
        t = (x * c - y * s) >>> 15;
        u = (x * s + y * c) >>> 15;
        hs = (t * longint'(r.squish)) >>> 13;
        vs = (u * longint'(r.inv_squish)) >>> 13;
        d2 = longint'(hs * hs + vs * vs);
        isc = 64'(r.inv_scale);
        // Reject large products before forming them, so nothing overflows.
        if ((d2 >> 20) * isc >= (64'd1 << 20))
            return 17'd0;
        p = d2 * isc;
        if (p >= SCORE_ONE)
            return 17'd0;
        return 17'((SCORE_ONE - p) >> 24);
    endfunction

    // Best score over the scanned bubbles for one tile position of the pixel.
    function automatic longint unsigned tile_best(input longint ph, input longint pv);
        int n;
        longint unsigned best, sc;
        n = (scan_count > SLOTS) ? SLOTS : int'(scan_count);
        best = 0;
        for (int i = 0; i < n; i++) begin
            sc = 64'(bubble_score(ph - longint'(bubble_table[i].center_h),
                                  pv - longint'(bubble_table[i].center_v),
                                  bubble_table[i]));
            if (sc > best)
                best = sc;
        end
        return best;
    endfunction

    // Height at one pixel over the main tile and its eight damped neighbours.
    function automatic logic [15:0] pixel_height(input logic [15:0] px_h,
                                                 input logic [15:0] px_v);
        longint unsigned wh [3];
        longint unsigned wv [3];
        longint unsigned val, best;
        wh[tbfh_pkg::TILE_NEG] = 64'(px_h);
        wh[tbfh_pkg::TILE_MID] = 0;
        wh[tbfh_pkg::TILE_POS] = 64'(tbfh_pkg::ONE_Q16) - 64'(px_h);
        wv[tbfh_pkg::TILE_NEG] = 64'(px_v);
        wv[tbfh_pkg::TILE_MID] = 0;
        wv[tbfh_pkg::TILE_POS] = 64'(tbfh_pkg::ONE_Q16) - 64'(px_v);
        best = 0;
        for (int dv = 0; dv < 3; dv++) begin
            for (int dh = 0; dh < 3; dh++) begin
                val = tile_best(longint'(px_h) + longint'(dh - 1) * 65536,
                                longint'(px_v) + longint'(dv - 1) * 65536);
                if (dh != tbfh_pkg::TILE_MID && dv != tbfh_pkg::TILE_MID)
                    val = (val * wh[dh] * wv[dv]) >> 32;
                else if (dh != tbfh_pkg::TILE_MID)
                    val = (val * wh[dh]) >> 16;
                else if (dv != tbfh_pkg::TILE_MID)
                    val = (val * wv[dv]) >> 16;
                if (val > best)
                    best = val;
            end
        end
        return (best > 64'(tbfh_pkg::HEIGHT_MAX)) ? tbfh_pkg::HEIGHT_MAX : best[15:0];
    endfunction

    // Update the table copy for a load, or queue the height for a query.
    function automatic void apply_word(input field_word_t w);
        if (w.func == tbfh_pkg::FUNC_LOAD)
            bubble_table[w.slot] = w.rec;
        else
            expected_heights.push_back(pixel_height(w.pixel_h, w.pixel_v));
    endfunction

    // ------------------------------------------------------------------------
    // Word construction
    // ------------------------------------------------------------------------

    function automatic tbfh_pkg::bubble_rec_t make_record(
        input logic [15:0] ch, input logic [15:0] cv,
        input logic [15:0] c, input logic [15:0] s,
        input logic [15:0] sq, input logic [15:0] isq,
        input logic [23:0] isc);
        tbfh_pkg::bubble_rec_t r;
        r.center_h = ch;
        r.center_v = cv;
        r.cos_angle = c;
        r.sin_angle = s;
        r.squish = sq;
        r.inv_squish = isq;
        r.inv_scale = isc;
        return r;
    endfunction

    // Mostly shapes near unit stretch and moderate scale, so scores are nonzero.
    function automatic tbfh_pkg::bubble_rec_t random_record();
        tbfh_pkg::bubble_rec_t r;
        r.center_h = 16'($urandom_range(16'hFFFF));
        r.center_v = 16'($urandom_range(16'hFFFF));
        r.cos_angle = 16'($urandom_range(16'hFFFF));
        r.sin_angle = 16'($urandom_range(16'hFFFF));
        r.squish = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF))
                                            : 16'($urandom_range(24576, 2048));
        r.inv_squish = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF))
                                                : 16'($urandom_range(24576, 2048));
        case ($urandom_range(9))
            6, 7:    r.inv_scale = 24'($urandom_range(24'hFFFFFF));
            8:       r.inv_scale = 24'($urandom_range(15));
            9:       r.inv_scale = 24'd0;
            default: r.inv_scale = 24'($urandom_range(4096, 8));
        endcase
        return r;
    endfunction

    // Unused fields carry random data, which the block must ignore.
    function automatic field_word_t load_word(input logic [4:0] slot,
                                              input tbfh_pkg::bubble_rec_t rec);
        field_word_t w;
        w.func = tbfh_pkg::FUNC_LOAD;
        w.slot = slot;
        w.rec = rec;
        w.pixel_h = 16'($urandom_range(16'hFFFF));
        w.pixel_v = 16'($urandom_range(16'hFFFF));
        return w;
    endfunction

    function automatic field_word_t query_word(input logic [15:0] ph, input logic [15:0] pv);
        field_word_t w;
        w.func = tbfh_pkg::FUNC_QUERY;
        w.slot = 5'($urandom_range(SLOTS - 1));
        w.rec = random_record();
        w.pixel_h = ph;
        w.pixel_v = pv;
        return w;
    endfunction

    // Pixels at or near a scanned bubble's centre hit the saturation case.
    function automatic field_word_t random_query();
        int n;
        int idx;
        logic [15:0] ph, pv;
        n = (scan_count > SLOTS) ? SLOTS : int'(scan_count);
        ph = 16'($urandom_range(16'hFFFF));
        pv = 16'($urandom_range(16'hFFFF));
        if (n > 0) begin
            idx = $urandom_range(n - 1);
            case ($urandom_range(7))
                0: begin
                    ph = bubble_table[idx].center_h;
                    pv = bubble_table[idx].center_v;
                end
                1, 2: begin
                    ph = bubble_table[idx].center_h + 16'($urandom_range(1023)) - 16'd512;
                    pv = bubble_table[idx].center_v + 16'($urandom_range(1023)) - 16'd512;
                end
                default: ;
            endcase
        end
        return query_word(ph, pv);
    endfunction

    function automatic field_word_t random_word();
        if ($urandom_range(99) < 35)
            return load_word(5'($urandom_range(SLOTS - 1)), random_record());
        return random_query();
    endfunction

    // ------------------------------------------------------------------------
    // Input channel and configuration
    // ------------------------------------------------------------------------

    // Offer one word, with random idle cycles first, and wait for acceptance.
    task automatic send_word(input field_word_t w);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= w.func;
        s_bubble_index <= w.slot;
        s_center_h     <= w.rec.center_h;
        s_center_v     <= w.rec.center_v;
        s_cos_angle    <= w.rec.cos_angle;
        s_sin_angle    <= w.rec.sin_angle;
        s_squish       <= w.rec.squish;
        s_inv_squish   <= w.rec.inv_squish;
        s_inv_scale    <= w.rec.inv_scale;
        s_pixel_h      <= w.pixel_h;
        s_pixel_v      <= w.pixel_v;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        apply_word(w);
    endtask

    task automatic end_stream();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // The count is written only once every query has returned and a trailing
    // load has had time to finish.
    task automatic write_count(input logic [5:0] value);
        while (expected_heights.size() != 0)
            @(posedge aclk);
        repeat (LOAD_SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        scan_count = value;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct = SEND_IDLE_PCT;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                recv_stall_pct = RECV_STALL_PCT;
            end
            IDLE_BOTH: begin
                send_idle_pct = BOTH_IDLE_PCT;
                recv_stall_pct = BOTH_IDLE_PCT;
            end
            default: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------------

    // Ready follows the stall rate, except during a long hold-off.
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void report_failure(input string what, input logic [15:0] want,
                                           input logic [15:0] got);
        failure_count++;
        if (failure_count <= REPORT_MAX)
            $display("cycle %0d: %s: expected height %h, got %h",
                     cycle_count, what, want, got);
    endfunction

    // Compare each returned word with the oldest expected height.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_heights.size() == 0) begin
                report_failure("height word with no query pending", 16'h0, m_height);
            end else begin
                height_due = expected_heights.pop_front();
                if (m_height !== height_due)
                    report_failure("height mismatch", height_due, m_height);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The count resets to zero, so every query returns zero height.
    task automatic test_empty_field();
        send_word(query_word(16'h0000, 16'h0000));
        send_word(query_word(16'hFFFF, 16'hFFFF));
        send_word(query_word(16'h8000, 16'h0001));
        end_stream();
    endtask

    // Hand-picked records: an oversized score term, a unit bubble whose
    // centre saturates at one, zero squish, rotations at both extremes, and
    // a zero scale term in the last slot.
    task automatic test_directed_records();
        send_word(load_word(5'd0, make_record(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                              16'hFFFF, 16'hFFFF, 24'hFFFFFF)));
        send_word(load_word(5'd1, make_record(16'h0000, 16'h0000, 16'h7FFF, 16'h0000,
                                              16'h2000, 16'h2000, 24'd512)));
        send_word(load_word(5'd2, make_record(16'h4000, 16'hC000, 16'h0000, 16'h7FFF,
                                              16'h0000, 16'h4000, 24'd256)));
        send_word(load_word(5'd3, make_record(16'h1234, 16'hABCD, 16'h5A82, 16'hA57E,
                                              16'h1000, 16'h4000, 24'd1024)));
        send_word(load_word(5'd31, make_record(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF,
                                               16'hFFFF, 16'h0000, 24'd0)));
        end_stream();
        write_count(6'd1);
        send_word(query_word(16'h0000, 16'h0000));
        send_word(query_word(16'hFFFF, 16'h0000));
        end_stream();
        write_count(6'd4);
        send_word(query_word(16'h0000, 16'h0000));
        send_word(query_word(16'h4000, 16'hC000));
        send_word(query_word(16'h1234, 16'hABCD));
        send_word(query_word(16'hFFFF, 16'hFFFF));
        send_word(query_word(16'h8000, 16'h8000));
        send_word(query_word(16'h0000, 16'hFFFF));
        end_stream();
    endtask

    // Load every slot so that any count scans only written records.
    task automatic test_fill_table();
        set_idling(IDLE_NONE);
        for (int i = 0; i < SLOTS; i++)
            send_word(load_word(5'(i), random_record()));
        end_stream();
    endtask

    // Random loads and queries under several counts, including zero, the
    // full table and counts above the table, each with its own idling.
    task automatic test_random_phases();
        logic [5:0] counts [12];
        counts = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd5, 6'd33,
                   6'd2, 6'd17, 6'd8, 6'd32, 6'd3, 6'd12};
        for (int p = 0; p < 12; p++) begin
            write_count(counts[p]);
            set_idling(idle_mode_t'(p % 4));
            repeat (PHASE_WORDS) send_word(random_word());
            end_stream();
        end
    endtask

    // The receiver holds off for a long stretch while queries keep coming,
    // so the block fills up and stalls its input.
    task automatic test_output_hold_off();
        write_count(6'd6);
        set_idling(IDLE_NONE);
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (60) begin
            if ($urandom_range(99) < 80)
                send_word(random_query());
            else
                send_word(random_word());
        end
        end_stream();
    endtask

    // Reset, run the tests in turn, then drain and report.
    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_field();
        test_directed_records();
        test_fill_table();
        test_random_phases();
        test_output_hold_off();
        set_idling(IDLE_NONE);
        while (expected_heights.size() != 0)
            @(posedge aclk);
        repeat (END_WAIT) @(posedge aclk);
        if (failure_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
